// File: src/word_break_way_counter_defines.svh
// Assertion macros used by the checker file of the word break way counter.
`ifndef WORD_BREAK_WAY_COUNTER_DEFINES_SVH
`define WORD_BREAK_WAY_COUNTER_DEFINES_SVH

// Clocked check, masked while reset is asserted.
`define WBC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define WBC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/wbc_pkg.sv
// Shared types and constants of the word break way counter.
`default_nettype none

package wbc_pkg;

	// Operation codes of an input transaction
	localparam logic OP_DICT_WRITE = 1'b0;
	localparam logic OP_SYMBOL     = 1'b1;

	localparam int COUNT_W = 63;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	typedef struct packed {
		logic        operation;
		logic [8:0]  entry_index;
		logic        entry_valid;
		logic [63:0] entry_bytes;
		logic [3:0]  entry_length;
		logic [7:0]  symbol;
		logic        last_symbol;
	} item_t;

	typedef struct packed {
		logic               possible;
		logic [COUNT_W-1:0] way_count;
		logic               saturated;
	} result_t;

	// One dictionary slot as stored in memory
	typedef struct packed {
		logic        valid;
		logic [3:0]  length;
		logic [63:0] bytes;
	} dict_entry_t;

	localparam int ENTRY_W = $bits(dict_entry_t);

	// Commands from controller to datapath
	typedef struct packed {
		logic clr;       // clearing pass write
		logic dict_wr;   // dictionary write transaction
		logic load_sym;  // shift a new symbol into the window
		logic rd;        // read one dictionary slot
		logic acc;       // read data valid, merge match flags
		logic sum_step;  // one saturating add
		logic commit;    // push the new count into the window, or reset it at design end
		logic emit;      // load the result register
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic item_op;
		logic last_q;
	} sts_t;

endpackage

`default_nettype wire

// File: src/wbc_ram.sv
// Generic simple dual port RAM with registered read.
`default_nettype none

module wbc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  wr_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                      wr_data,
	input  wire logic                                  rd_en,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                      rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

// File: src/wbc_ctrl.sv
// Controller: clearing pass, handshakes and per-symbol scan/sum sequencing.
`default_nettype none

module wbc_ctrl #(
	parameter int DICT_DEPTH      = 512,
	parameter int MAX_PATTERN_LEN = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	input  wire wbc_pkg::sts_t         sts,
	output wbc_pkg::cmd_t              cmd,
	output logic [(DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1)-1:0] addr,
	output logic [(MAX_PATTERN_LEN > 1 ? $clog2(MAX_PATTERN_LEN) : 1)-1:0] sum_idx
);

	localparam int ADDR_W = DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1;
	localparam int SUM_W  = MAX_PATTERN_LEN > 1 ? $clog2(MAX_PATTERN_LEN) : 1;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DICT_DEPTH - 1);
	localparam logic [SUM_W-1:0]  LAST_SUM  = SUM_W'(MAX_PATTERN_LEN - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_SUM,
		ST_FINISH
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SUM_W-1:0]  sum_q;
	logic              rd_pend_q;
	logic              result_valid_q;
	logic              take;
	logic              out_free;

	// Command decode
	always_comb begin
		item_ready   = (state_q == ST_IDLE);
		take         = item_valid && item_ready;
		out_free     = !result_valid_q || result_ready;
		cmd          = '0;
		cmd.clr      = (state_q == ST_CLEAR);
		cmd.dict_wr  = take && (sts.item_op == wbc_pkg::OP_DICT_WRITE);
		cmd.load_sym = take && (sts.item_op == wbc_pkg::OP_SYMBOL);
		cmd.rd       = (state_q == ST_SCAN);
		cmd.acc      = rd_pend_q;
		cmd.sum_step = (state_q == ST_SUM);
		cmd.commit   = (state_q == ST_FINISH) && (!sts.last_q || out_free);
		cmd.emit     = cmd.commit && sts.last_q;
	end

	assign addr         = addr_q;
	assign sum_idx      = sum_q;
	assign result_valid = result_valid_q;

	// State and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			addr_q         <= '0;
			sum_q          <= '0;
			rd_pend_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == ST_SCAN);
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (cmd.load_sym) begin
						addr_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						addr_q  <= '0;
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					sum_q   <= '0;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					if (sum_q == LAST_SUM) begin
						state_q <= ST_FINISH;
					end else begin
						sum_q <= sum_q + 1'b1;
					end
				end
				ST_FINISH: begin
					if (cmd.commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/wbc_dp.sv
// Datapath: dictionary memory, symbol window, match flags and saturating sum.
`default_nettype none

module wbc_dp #(
	parameter int DICT_DEPTH      = 512,
	parameter int MAX_PATTERN_LEN = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire wbc_pkg::item_t        item,
	input  wire wbc_pkg::cmd_t         cmd,
	input  wire logic [(DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1)-1:0] addr,
	input  wire logic [(MAX_PATTERN_LEN > 1 ? $clog2(MAX_PATTERN_LEN) : 1)-1:0] sum_idx,
	output wbc_pkg::sts_t              sts,
	output wbc_pkg::result_t           result
);

	localparam int ADDR_W = DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1;
	localparam int CW     = wbc_pkg::COUNT_W;

	wbc_pkg::dict_entry_t wr_data;
	wbc_pkg::dict_entry_t rd_data;
	logic [ADDR_W-1:0]    wr_addr;
	logic                 wr_en;
	logic                 idx_ok;
	logic [31:0]          idx_ext;

	logic [7:0]                 recent_q  [MAX_PATTERN_LEN];
	logic [CW-1:0]              prefix_q  [MAX_PATTERN_LEN];
	logic [MAX_PATTERN_LEN-1:0] matched_q;
	logic [CW-1:0]              total_q;
	logic                       sat_q;
	logic                       last_q;

	logic [MAX_PATTERN_LEN-1:0] eq;
	logic [MAX_PATTERN_LEN-1:0] hit;
	logic [CW-1:0]              addend;
	logic [CW:0]                sum_w;
	logic [CW-1:0]              sum_sat;

	// Memory write port: clearing pass or dictionary transaction
	always_comb begin
		idx_ext = 32'(item.entry_index);
		idx_ok  = idx_ext < 32'(DICT_DEPTH);
		wr_en   = cmd.clr || (cmd.dict_wr && idx_ok);
		wr_addr = cmd.clr ? addr : idx_ext[ADDR_W-1:0];
		if (cmd.clr) begin
			wr_data = '0;
		end else begin
			wr_data.valid  = item.entry_valid;
			wr_data.length = item.entry_length;
			wr_data.bytes  = item.entry_bytes;
		end
	end

	wbc_ram #(
		.WIDTH (wbc_pkg::ENTRY_W),
		.DEPTH (DICT_DEPTH)
	) u_dict (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.rd),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	// Suffix compare for every pattern length against the slot just read
	always_comb begin
		for (int l = 1; l <= MAX_PATTERN_LEN; l++) begin
			eq[l-1] = 1'b1;
			for (int k = 0; k < l; k++) begin
				if (rd_data.bytes[8*k +: 8] != recent_q[l-1-k]) begin
					eq[l-1] = 1'b0;
				end
			end
			hit[l-1] = rd_data.valid && (rd_data.length == 4'(l)) && eq[l-1];
		end
	end

	// One saturating add per step
	always_comb begin
		addend  = matched_q[sum_idx] ? prefix_q[sum_idx] : '0;
		sum_w   = {1'b0, total_q} + {1'b0, addend};
		sum_sat = sum_w[CW] ? wbc_pkg::COUNT_MAX : sum_w[CW-1:0];
	end

	// Window, match flags and running sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
				recent_q[j] <= '0;
				prefix_q[j] <= (j == 0) ? CW'(1) : '0;
			end
			matched_q <= '0;
			total_q   <= '0;
			sat_q     <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			if (cmd.load_sym) begin
				for (int j = MAX_PATTERN_LEN - 1; j > 0; j--) begin
					recent_q[j] <= recent_q[j-1];
				end
				recent_q[0] <= item.symbol;
				last_q      <= item.last_symbol;
				matched_q   <= '0;
				total_q     <= '0;
			end
			if (cmd.acc) begin
				matched_q <= matched_q | hit;
			end
			if (cmd.sum_step) begin
				total_q <= sum_sat;
				if (sum_w[CW]) begin
					sat_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if (last_q) begin
					// design done: window back to its start
					for (int j = 0; j < MAX_PATTERN_LEN; j++) begin
						recent_q[j] <= '0;
						prefix_q[j] <= (j == 0) ? CW'(1) : '0;
					end
					sat_q <= 1'b0;
				end else begin
					for (int j = MAX_PATTERN_LEN - 1; j > 0; j--) begin
						prefix_q[j] <= prefix_q[j-1];
					end
					prefix_q[0] <= total_q;
				end
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			result.possible  <= (total_q != '0);
			result.way_count <= total_q;
			result.saturated <= sat_q;
		end
	end

	assign sts.item_op = item.operation;
	assign sts.last_q  = last_q;

endmodule

`default_nettype wire

// File: src/word_break_way_counter.sv
// Top level of the word break way counter: controller plus datapath.
//
//  channel | signals                       | direction | moves
//  --------+-------------------------------+-----------+---------------------------
//  item    | item_valid, item_ready, item  | in        | dictionary write or symbol
//  result  | result_valid, result_ready,   | out       | way count at design end
//          | result                        |           |
//
// For a symbol, one dictionary slot is read and matched per cycle, then one saturating
// add is done per length.
// After reset a clearing pass zeroes every dictionary slot with item_ready low.
// A finished result waits in the output register; a following design's last
// symbol holds in its final cycle until that register is free.
`default_nettype none

module word_break_way_counter #(
	parameter int DICT_DEPTH      = 512,
	parameter int MAX_PATTERN_LEN = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire wbc_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output wbc_pkg::result_t      result
);

	localparam int ADDR_W = DICT_DEPTH > 1 ? $clog2(DICT_DEPTH) : 1;
	localparam int SUM_W  = MAX_PATTERN_LEN > 1 ? $clog2(MAX_PATTERN_LEN) : 1;

	wbc_pkg::cmd_t     cmd;
	wbc_pkg::sts_t     sts;
	logic [ADDR_W-1:0] addr;
	logic [SUM_W-1:0]  sum_idx;

	wbc_ctrl #(
		.DICT_DEPTH      (DICT_DEPTH),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.sts          (sts),
		.cmd          (cmd),
		.addr         (addr),
		.sum_idx      (sum_idx)
	);

	wbc_dp #(
		.DICT_DEPTH      (DICT_DEPTH),
		.MAX_PATTERN_LEN (MAX_PATTERN_LEN)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.cmd     (cmd),
		.addr    (addr),
		.sum_idx (sum_idx),
		.sts     (sts),
		.result  (result)
	);

endmodule

`default_nettype wire

// File: src/wbc_chk.sv
// Port-level checker for the word break way counter and its bind.
`default_nettype none

`include "word_break_way_counter_defines.svh"

module wbc_chk (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_ready,
	input wire wbc_pkg::item_t   item,
	input wire logic             result_valid,
	input wire logic             result_ready,
	input wire wbc_pkg::result_t result
);

	// A stalled result transaction holds
	`WBC_ASSERT(a_result_hold, result_valid && !result_ready |=> result_valid && $stable(result), "result changed while stalled")

	// possible flag agrees with the count
	`WBC_ASSERT(a_possible, result_valid |-> result.possible == (result.way_count != '0), "possible flag does not match way count")

	// A symbol starts a dictionary scan, so no transaction is taken next cycle
	`WBC_ASSERT(a_scan_busy, item_valid && item_ready && item.operation == wbc_pkg::OP_SYMBOL |=> !item_ready, "transaction taken during dictionary scan")

	// Nothing is taken or offered while reset is asserted
	`WBC_ASSERT_RST(a_reset_quiet, !arst_n |-> !item_ready && !result_valid, "handshake active in reset")

endmodule

bind word_break_way_counter wbc_chk u_chk (.*);

`default_nettype wire
